// ===== src/tws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants for the two-wire display sender
// Phase codes, register indexes, command bytes, the segment decoder and the
// structures that pass between the sequencer and the output stage.
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int MAX_DIGITS  = 6;
  localparam int SLOT_W      = $clog2(MAX_DIGITS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [7:0] CMD_DATA  = 8'h40;
  localparam logic [7:0] CMD_ADDR  = 8'hC0;
  localparam logic [7:0] CMD_CTRL  = 8'h80;
  localparam logic [7:0] COLON_BIT = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS     = 2'd0,
    REG_DISPLAY_ENABLE = 2'd1,
    REG_COLON_ENABLE   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_S0, PH_S1, PH_S2, PH_S3,
    PH_B0, PH_B1, PH_B2,
    PH_A0, PH_A1, PH_A2, PH_A3,
    PH_P0, PH_P1, PH_P2, PH_P3
  } phase_t;

  typedef struct packed {
    logic [2:0] brightness;
    logic       display_enable;
    logic       colon_enable;
  } cfg_t;

  typedef struct packed {
    logic clk_level;
    logic dio_level;
    logic dio_drive;
    logic busy_res;
    logic request_refused;
    logic sequence_done;
  } res_t;

  // Digits above nine show blank.
  function automatic logic [7:0] seg_encode(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== src/two_wire_segment_display_sender_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_segment_display_sender_core: two-wire display writer
// Replays the start, byte, acknowledge and stop pin sequence of a four-digit
// seven-segment display controller, at most one pin change per tick item.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  input    in_valid / in_ready    op, digit_first..digit_fourth, dio_sample
//  output   out_valid / out_ready  clk_level, dio_level, dio_drive, busy_res,
//                                  request_refused, sequence_done
//  config   cfg_write              cfg_index, cfg_data
//
// The sequencer state moves on the accepting edge, and the result is loaded
// into the output register on that same edge.
// in_ready is high whenever the output register is empty or being read, so
// one item per clock is sustained while out_ready stays high.
// Reset clears the sequencer to idle and loads brightness 1, display on and
// colon on; each request taken while idle writes the latched segment bytes.
// ----------------------------------------------------------------------------
module two_wire_segment_display_sender_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [3:0]                     digit_first,
  input  logic [3:0]                     digit_second,
  input  logic [3:0]                     digit_third,
  input  logic [3:0]                     digit_fourth,
  input  logic                           dio_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           clk_level,
  output logic                           dio_level,
  output logic                           dio_drive,
  output logic                           busy_res,
  output logic                           request_refused,
  output logic                           sequence_done,
  input  logic                           cfg_write,
  input  logic [tws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tws_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tws_pkg::*;

  cfg_t cfg;
  res_t res_step, res_held;
  logic accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness     <= 3'd1;
      cfg.display_enable <= 1'b1;
      cfg.colon_enable   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BRIGHTNESS:     cfg.brightness     <= cfg_data;
        REG_DISPLAY_ENABLE: cfg.display_enable <= cfg_data[0];
        REG_COLON_ENABLE:   cfg.colon_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tws_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .adv          (accept),
    .op           (op),
    .digit_first  (digit_first),
    .digit_second (digit_second),
    .digit_third  (digit_third),
    .digit_fourth (digit_fourth),
    .dio_sample   (dio_sample),
    .cfg          (cfg),
    .res          (res_step)
  );

  tws_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res_in    (res_step),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .space     (in_ready),
    .res_out   (res_held)
  );

  assign clk_level       = res_held.clk_level;
  assign dio_level       = res_held.dio_level;
  assign dio_drive       = res_held.dio_drive;
  assign busy_res        = res_held.busy_res;
  assign request_refused = res_held.request_refused;
  assign sequence_done   = res_held.sequence_done;

endmodule

// ===== src/tws_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_seq: pin sequencer
// Holds the phase, shift and slot state and the latched segment bytes, and
// advances by at most one pin action for every accepted item.
// ----------------------------------------------------------------------------
module tws_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          op,
  input  logic [3:0]    digit_first,
  input  logic [3:0]    digit_second,
  input  logic [3:0]    digit_third,
  input  logic [3:0]    digit_fourth,
  input  logic          dio_sample,
  input  tws_pkg::cfg_t cfg,
  output tws_pkg::res_t res
);
  import tws_pkg::*;

  phase_t            phase, phase_next;
  logic [2:0]        bit_index, bit_index_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [SLOT_W-1:0] byte_slot, byte_slot_next;
  logic [1:0]        transaction_index, transaction_index_next;
  logic              clk_out, clk_out_next;
  logic              dio_out, dio_out_next;
  logic              dio_driven, dio_driven_next;
  logic [7:0]        segment_bytes [MAX_DIGITS];
  logic [3:0]        digits [4];
  logic              start, refused, done;
  logic              more_digits;
  logic [7:0]        ctrl_byte;

  assign digits[0] = digit_first;
  assign digits[1] = digit_second;
  assign digits[2] = digit_third;
  assign digits[3] = digit_fourth;

  assign start       = op && (phase == PH_IDLE);
  assign refused     = op && (phase != PH_IDLE);
  assign more_digits = (transaction_index == 2'd1) && (byte_slot < SLOT_W'(DIGIT_COUNT));
  assign ctrl_byte   = CMD_CTRL | {4'd0, cfg.display_enable, cfg.brightness};

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (op) begin
      if (start) begin
        phase_next = PH_S0;
      end
    end else begin
      unique case (phase)
        PH_S0: phase_next = PH_S1;
        PH_S1: phase_next = PH_S2;
        PH_S2: phase_next = PH_S3;
        PH_S3: phase_next = PH_B0;
        PH_B0: phase_next = PH_B1;
        PH_B1: phase_next = PH_B2;
        PH_B2: phase_next = (bit_index == 3'd7) ? PH_A0 : PH_B0;
        PH_A0: phase_next = PH_A1;
        PH_A1: phase_next = dio_sample ? PH_A1 : PH_A2;
        PH_A2: phase_next = PH_A3;
        PH_A3: phase_next = more_digits ? PH_B0 : PH_P0;
        PH_P0: phase_next = PH_P1;
        PH_P1: phase_next = PH_P2;
        PH_P2: phase_next = PH_P3;
        PH_P3: phase_next = (transaction_index == 2'd2) ? PH_IDLE : PH_S0;
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // Datapath and pin levels.
  always_comb begin
    bit_index_next         = bit_index;
    shift_byte_next        = shift_byte;
    byte_slot_next         = byte_slot;
    transaction_index_next = transaction_index;
    clk_out_next           = clk_out;
    dio_out_next           = dio_out;
    dio_driven_next        = dio_driven;
    done                   = 1'b0;
    if (op) begin
      if (start) begin
        bit_index_next         = 3'd0;
        byte_slot_next         = '0;
        transaction_index_next = 2'd0;
      end
    end else begin
      unique case (phase)
        PH_S0: begin
          dio_out_next    = 1'b1;
          dio_driven_next = 1'b1;
        end
        PH_S1: clk_out_next = 1'b1;
        PH_S2: dio_out_next = 1'b0;
        PH_S3: begin
          clk_out_next   = 1'b0;
          byte_slot_next = '0;
          bit_index_next = 3'd0;
          if (transaction_index == 2'd0) begin
            shift_byte_next = CMD_DATA;
          end else if (transaction_index == 2'd1) begin
            shift_byte_next = CMD_ADDR;
          end else begin
            shift_byte_next = ctrl_byte;
          end
        end
        PH_B0: dio_out_next = shift_byte[0];
        PH_B1: clk_out_next = 1'b1;
        PH_B2: begin
          clk_out_next    = 1'b0;
          shift_byte_next = {1'b0, shift_byte[7:1]};
          bit_index_next  = (bit_index == 3'd7) ? 3'd0 : bit_index + 3'd1;
        end
        PH_A0: begin
          clk_out_next    = 1'b0;
          dio_driven_next = 1'b0;
        end
        PH_A1: begin
          if (!dio_sample) begin
            dio_driven_next = 1'b1;
          end
        end
        PH_A2: clk_out_next = 1'b1;
        PH_A3: begin
          clk_out_next = 1'b0;
          if (more_digits) begin
            shift_byte_next = segment_bytes[byte_slot];
            byte_slot_next  = byte_slot + SLOT_W'(1);
            bit_index_next  = 3'd0;
          end
        end
        PH_P0: dio_out_next = 1'b0;
        PH_P1: clk_out_next = 1'b1;
        PH_P2: dio_out_next = 1'b1;
        PH_P3: begin
          clk_out_next = 1'b0;
          if (transaction_index == 2'd2) begin
            transaction_index_next = 2'd0;
            byte_slot_next         = '0;
            done                   = 1'b1;
          end else begin
            transaction_index_next = transaction_index + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res.clk_level       = clk_out_next;
    res.dio_level       = dio_out_next;
    res.dio_drive       = dio_driven_next;
    res.busy_res        = (phase_next != PH_IDLE);
    res.request_refused = refused;
    res.sequence_done   = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      bit_index         <= 3'd0;
      shift_byte        <= 8'd0;
      byte_slot         <= '0;
      transaction_index <= 2'd0;
      clk_out           <= 1'b0;
      dio_out           <= 1'b0;
      dio_driven        <= 1'b1;
    end else if (adv) begin
      phase             <= phase_next;
      bit_index         <= bit_index_next;
      shift_byte        <= shift_byte_next;
      byte_slot         <= byte_slot_next;
      transaction_index <= transaction_index_next;
      clk_out           <= clk_out_next;
      dio_out           <= dio_out_next;
      dio_driven        <= dio_driven_next;
    end
  end

  // Segment bytes are written only when a request is taken while idle.
  always_ff @(posedge clk) begin
    if (adv && start) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (i < 4) begin
          segment_bytes[i] <= seg_encode(digits[i]) |
                              (((i == 1) && cfg.colon_enable) ? COLON_BIT : 8'h00);
        end else begin
          segment_bytes[i] <= 8'h00;
        end
      end
    end
  end

endmodule

// ===== src/tws_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_out_stage: result register
// Holds one finished result and frees itself in the cycle it is taken, so
// that a new item can enter on every clock while out_ready stays high.
// ----------------------------------------------------------------------------
module tws_out_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  tws_pkg::res_t res_in,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          space,
  output tws_pkg::res_t res_out
);
  import tws_pkg::*;

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== tb/two_wire_segment_display_sender_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_wire_segment_display_sender_core_test: pin sequence check
// A queue of tick and request items, with register writes and sync points
// between them, feeds a valid/ready driver. Every accepted item is run
// through a cycle-free model of the start, byte, acknowledge and stop
// sequencer, and the result it predicts is compared field by field with the
// block's output. Both sides idle at random, one long output stall forces the
// block to back up, and the last stretch of the run has no idling.
// ----------------------------------------------------------------------------
module two_wire_segment_display_sender_core_test;
  import tws_pkg::*;

  typedef enum logic {OP_TICK = 1'b0, OP_REQUEST = 1'b1} op_code_t;
  typedef enum logic [1:0] {ENTRY_PIN, ENTRY_REG, ENTRY_SYNC} entry_kind_t;

  typedef struct packed {
    entry_kind_t                kind;
    logic                       op;
    logic [3:0]                 d1;
    logic [3:0]                 d2;
    logic [3:0]                 d3;
    logic [3:0]                 d4;
    logic                       dio;
    reg_idx_t                   idx;
    logic [CFG_DATA_W-1:0]      val;
  } entry_t;

  // Segment patterns, digit 0 in the low byte; digits above nine are blank.
  localparam logic [16*8-1:0] GLYPHS = {
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h6f, 8'h7f,
    8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
  };
  localparam int QUIET_TAIL_ITEMS = 150;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 80;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  op = 1'b0;
  logic [3:0]            digit_first = 4'd0;
  logic [3:0]            digit_second = 4'd0;
  logic [3:0]            digit_third = 4'd0;
  logic [3:0]            digit_fourth = 4'd0;
  logic                  dio_sample = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  clk_level;
  logic                  dio_level;
  logic                  dio_drive;
  logic                  busy_res;
  logic                  request_refused;
  logic                  sequence_done;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  two_wire_segment_display_sender_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .digit_first(digit_first), .digit_second(digit_second),
    .digit_third(digit_third), .digit_fourth(digit_fourth),
    .dio_sample(dio_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .clk_level(clk_level), .dio_level(dio_level), .dio_drive(dio_drive),
    .busy_res(busy_res), .request_refused(request_refused),
    .sequence_done(sequence_done),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Model state of the sequencer and its registers.
  phase_t             ph = PH_IDLE;
  logic [2:0]         bit_cnt = '0;
  logic [7:0]         shreg = '0;
  logic [SLOT_W-1:0]  slot = '0;
  logic [1:0]         txn = '0;
  logic [7:0]         glyph [MAX_DIGITS] = '{default: 8'h00};
  logic               clk_o = 1'b0;
  logic               dio_o = 1'b0;
  logic               dio_en = 1'b1;
  logic [2:0]         brightness = 3'd1;
  logic               disp_en = 1'b1;
  logic               colon_en = 1'b1;

  entry_t      display_items [$];
  res_t        pin_state_due [$];
  entry_t      cur_item = '0;
  entry_t      head_item;
  res_t        got;
  logic        took;
  logic        wr_now;
  logic        quiet_tail = 1'b0;
  logic        tx_mode = 1'b1;
  logic        rx_mode = 1'b1;
  logic [5:0]  tx_cycle = '0;
  logic [5:0]  rx_cycle = '0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  logic        long_hold_done = 1'b0;
  int unsigned pins_accepted = 0;
  int unsigned regs_written = 0;
  int unsigned results_seen = 0;
  int unsigned sequences_seen = 0;
  int unsigned refusals_seen = 0;
  int unsigned mismatches = 0;

  function automatic logic [7:0] glyph_of(input logic [3:0] d);
    return GLYPHS[d*8 +: 8];
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    shreg = b;
    bit_cnt = '0;
    ph = PH_B0;
  endfunction

  // Applies one item to the model and returns the pin levels after it.
  function automatic res_t advance_display(input entry_t it);
    res_t r;
    logic refused;
    logic done;
    refused = 1'b0;
    done = 1'b0;
    if (it.op == OP_REQUEST) begin
      if (ph != PH_IDLE) begin
        refused = 1'b1;
      end else begin
        glyph[0] = glyph_of(it.d1);
        glyph[1] = glyph_of(it.d2) | (colon_en ? COLON_BIT : 8'h00);
        glyph[2] = glyph_of(it.d3);
        glyph[3] = glyph_of(it.d4);
        txn = '0;
        slot = '0;
        bit_cnt = '0;
        ph = PH_S0;
      end
    end else begin
      case (ph)
        PH_S0: begin
          dio_o = 1'b1;
          dio_en = 1'b1;
          ph = PH_S1;
        end
        PH_S1: begin
          clk_o = 1'b1;
          ph = PH_S2;
        end
        PH_S2: begin
          dio_o = 1'b0;
          ph = PH_S3;
        end
        PH_S3: begin
          clk_o = 1'b0;
          slot = '0;
          if (txn == 2'd0) load_byte(CMD_DATA);
          else if (txn == 2'd1) load_byte(CMD_ADDR);
          else load_byte(CMD_CTRL | {4'b0000, disp_en, brightness});
        end
        PH_B0: begin
          dio_o = shreg[0];
          ph = PH_B1;
        end
        PH_B1: begin
          clk_o = 1'b1;
          ph = PH_B2;
        end
        PH_B2: begin
          clk_o = 1'b0;
          shreg = shreg >> 1;
          if (bit_cnt == 3'd7) begin
            bit_cnt = '0;
            ph = PH_A0;
          end else begin
            bit_cnt = bit_cnt + 3'd1;
            ph = PH_B0;
          end
        end
        PH_A0: begin
          clk_o = 1'b0;
          dio_en = 1'b0;
          ph = PH_A1;
        end
        PH_A1: begin
          // The display pulls the line low to acknowledge.
          if (!it.dio) begin
            dio_en = 1'b1;
            ph = PH_A2;
          end
        end
        PH_A2: begin
          clk_o = 1'b1;
          ph = PH_A3;
        end
        PH_A3: begin
          clk_o = 1'b0;
          if (txn == 2'd1 && slot < DIGIT_COUNT) begin
            load_byte(glyph[slot]);
            slot = slot + 1'b1;
          end else begin
            ph = PH_P0;
          end
        end
        PH_P0: begin
          dio_o = 1'b0;
          ph = PH_P1;
        end
        PH_P1: begin
          clk_o = 1'b1;
          ph = PH_P2;
        end
        PH_P2: begin
          dio_o = 1'b1;
          ph = PH_P3;
        end
        PH_P3: begin
          clk_o = 1'b0;
          if (txn >= 2'd2) begin
            txn = '0;
            slot = '0;
            ph = PH_IDLE;
            done = 1'b1;
          end else begin
            txn = txn + 2'd1;
            ph = PH_S0;
          end
        end
        default: ph = PH_IDLE;
      endcase
    end
    r.clk_level = clk_o;
    r.dio_level = dio_o;
    r.dio_drive = dio_en;
    r.busy_res = (ph != PH_IDLE);
    r.request_refused = refused;
    r.sequence_done = done;
    return r;
  endfunction

  function automatic void push_pin(input op_code_t o, input logic [3:0] a, input logic [3:0] b,
                                   input logic [3:0] c, input logic [3:0] d, input logic s);
    entry_t e;
    e = '0;
    e.kind = ENTRY_PIN;
    e.op = o;
    e.d1 = a;
    e.d2 = b;
    e.d3 = c;
    e.d4 = d;
    e.dio = s;
    display_items.push_back(e);
  endfunction

  function automatic void push_reg(input reg_idx_t i, input logic [CFG_DATA_W-1:0] v);
    entry_t e;
    e = '0;
    e.kind = ENTRY_REG;
    e.idx = i;
    e.val = v;
    display_items.push_back(e);
  endfunction

  function automatic logic [3:0] any_digit();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic void check_field(input string name, input logic want, input logic seen);
    if (seen !== want) begin
      $display("%0t ns: %s mismatch, expected %0b, got %0b", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  // Driver: one item per handshake, registers and sync points only once the
  // block has nothing left in flight.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      wr_now = 1'b0;
      if (took) begin
        pin_state_due.push_back(advance_display(cur_item));
        pins_accepted <= pins_accepted + 1;
      end
      if (in_valid && !took) begin
        // Hold the offered item.
      end else if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (display_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (display_items[0].kind == ENTRY_PIN) begin
        if (!quiet_tail && tx_mode && $urandom_range(0, 4) == 0) begin
          tx_gap <= $urandom_range(0, 5);
          in_valid <= 1'b0;
        end else begin
          cur_item = display_items.pop_front();
          op <= cur_item.op;
          digit_first <= cur_item.d1;
          digit_second <= cur_item.d2;
          digit_third <= cur_item.d3;
          digit_fourth <= cur_item.d4;
          dio_sample <= cur_item.dio;
          in_valid <= 1'b1;
        end
      end else if (!in_valid && !out_valid && pin_state_due.size() == 0) begin
        head_item = display_items.pop_front();
        if (head_item.kind == ENTRY_REG) begin
          wr_now = 1'b1;
          cfg_index <= head_item.idx;
          cfg_data <= head_item.val;
          regs_written <= regs_written + 1;
          case (head_item.idx)
            REG_BRIGHTNESS:     brightness = head_item.val;
            REG_DISPLAY_ENABLE: disp_en = head_item.val[0];
            REG_COLON_ENABLE:   colon_en = head_item.val[0];
            default: ;
          endcase
        end
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b0;
      end
      cfg_write <= wr_now;
      quiet_tail <= (display_items.size() < QUIET_TAIL_ITEMS);
      tx_cycle <= tx_cycle + 6'd1;
      if (tx_cycle == 6'd0) begin
        tx_mode <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Receiver: short random stalls, and one long one that backs the block up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && pins_accepted >= LONG_HOLD_AT) begin
        long_hold_done <= 1'b1;
        rx_stall <= LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!quiet_tail && rx_mode && $urandom_range(0, 4) == 0) begin
        rx_stall <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      rx_cycle <= rx_cycle + 6'd1;
      if (rx_cycle == 6'd0) begin
        rx_mode <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {clk_level, dio_level, dio_drive, busy_res, request_refused, sequence_done};
      results_seen <= results_seen + 1;
      if (got.sequence_done === 1'b1) sequences_seen <= sequences_seen + 1;
      if (got.request_refused === 1'b1) refusals_seen <= refusals_seen + 1;
      if (pin_state_due.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, got %b", $time, got);
        mismatches++;
      end else begin
        check_field("clk_level", pin_state_due[0].clk_level, got.clk_level);
        check_field("dio_level", pin_state_due[0].dio_level, got.dio_level);
        check_field("dio_drive", pin_state_due[0].dio_drive, got.dio_drive);
        check_field("busy_res", pin_state_due[0].busy_res, got.busy_res);
        check_field("request_refused", pin_state_due[0].request_refused,
                    got.request_refused);
        check_field("sequence_done", pin_state_due[0].sequence_done, got.sequence_done);
        void'(pin_state_due.pop_front());
      end
    end
  end

  initial begin
    int unsigned low_pct;
    int unsigned ticks;
    logic [2:0] bri;
    logic de;
    logic col;
    entry_t sync_mark;

    // Ticks while idle, a request with blank and extreme digits, a request
    // refused while busy, then the first byte up to its acknowledge, where
    // a high data line keeps the sequencer waiting.
    push_pin(OP_TICK, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1);
    push_pin(OP_TICK, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0);
    push_pin(OP_REQUEST, 4'd0, 4'd15, 4'd9, 4'd10, 1'b1);
    push_pin(OP_REQUEST, 4'd8, 4'd7, 4'd1, 4'd2, 1'b0);
    for (int i = 0; i < 29; i++) begin
      push_pin(OP_TICK, any_digit(), any_digit(), any_digit(), any_digit(), 1'($urandom));
    end
    push_pin(OP_TICK, 4'd0, 4'd0, 4'd0, 4'd0, 1'b1);
    push_pin(OP_TICK, 4'd15, 4'd15, 4'd15, 4'd15, 1'b1);
    push_pin(OP_TICK, 4'd3, 4'd4, 4'd5, 4'd6, 1'b0);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin bri = 3'd7; de = 1'b0; col = 1'b0; end
        1: begin bri = 3'd0; de = 1'b1; col = 1'b1; end
        3: begin bri = 3'd7; de = 1'b1; col = 1'b0; end
        5: begin bri = 3'd0; de = 1'b0; col = 1'b1; end
        default: begin
          bri = 3'($urandom_range(0, 7));
          de = 1'($urandom);
          col = 1'($urandom);
        end
      endcase
      push_reg(REG_BRIGHTNESS, bri);
      push_reg(REG_DISPLAY_ENABLE, {2'($urandom_range(0, 3)), de});
      push_reg(REG_COLON_ENABLE, {2'($urandom_range(0, 3)), col});
      // A full display sequence needs about 220 ticks; shorter runs leave it
      // unfinished so that the next request is refused and the ticks go on.
      low_pct = $urandom_range(40, 95);
      ticks = $urandom_range(190, 250);
      push_pin(OP_REQUEST, any_digit(), any_digit(), any_digit(), any_digit(),
               1'($urandom));
      for (int i = 0; i < ticks; i++) begin
        if ($urandom_range(0, 99) < 3) begin
          push_pin(OP_REQUEST, any_digit(), any_digit(), any_digit(), any_digit(),
                   1'($urandom));
        end
        push_pin(OP_TICK, any_digit(), any_digit(), any_digit(), any_digit(),
                 ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1);
        if (p == 2 && i == 100) begin
          sync_mark = '0;
          sync_mark.kind = ENTRY_SYNC;
          display_items.push_back(sync_mark);
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (!(display_items.size() == 0 && !in_valid && !out_valid
             && pin_state_due.size() == 0));
    repeat (8) @(posedge clk);

    $display("Run covered %0d items and %0d results: %0d display sequences finished,",
             pins_accepted, results_seen, sequences_seen);
    $display("%0d requests refused while busy, %0d register writes.",
             refusals_seen, regs_written);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== two_wire_segment_display_sender_core.f =====
src/tws_pkg.sv
src/tws_seq.sv
src/tws_out_stage.sv
src/two_wire_segment_display_sender_core.sv
tb/two_wire_segment_display_sender_core_test.sv
